@@ sv/fmipr_pkg.sv @@
// shared types and constants of the first-match ip range filter
package fmipr_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned ID_W   = 32;
	localparam int unsigned PLEN_W = 6;

	localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [PLEN_W-1:0] ADDR_BITS = 6'd32;

	typedef enum logic [2:0] {
		MODE_LOOKUP  = 3'd0,
		MODE_ADD     = 3'd1,
		MODE_REMOVE  = 3'd2,
		MODE_UPDATE  = 3'd3,
		MODE_ENABLE  = 3'd4,
		MODE_DISABLE = 3'd5,
		MODE_CLEAR   = 3'd6
	} mode_t;

	localparam logic [1:0] FORM_PREFIX = 2'd0;
	localparam logic [1:0] FORM_RANGE  = 2'd1;

	localparam logic [1:0] ACT_ALLOW = 2'd0;
	localparam logic [1:0] ACT_BLOCK = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] first;
		logic [ADDR_W-1:0] last;
		logic [1:0]        action;
		logic              enabled;
		logic [ID_W-1:0]   id;
	} entry_t;

endpackage

@@ sv/first_match_ip_range_filter_unit.sv @@
// top level of the first-match ip range filter: ordered rule table with sequential scan
// add, clear, unused modes and any search of an empty table give done in the cycle after
// the request is taken; lookup, remove, update, enable and disable otherwise scan one rule
// per cycle through the single ram read port until the slot that decides or the last slot;
// remove then moves each later rule up one slot per cycle
// throughput: one request at a time, busy drops in the cycle done is high; no result stall
// reset clears the rule count and sets the next id to one; rule storage is not cleared
module first_match_ip_range_filter_unit #(
	parameter int unsigned RULE_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [31:0] rule_id,
	input  logic [31:0] address,
	input  logic [31:0] last_address,
	input  logic [1:0]  range_form,
	input  logic [5:0]  prefix_len,
	input  logic [1:0]  rule_action,
	input  logic        rule_enabled,
	output logic        done,
	output logic        ok,
	output logic [1:0]  found_action,
	output logic        allowed,
	output logic [31:0] new_id
);

	localparam int unsigned IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(RULE_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(RULE_SLOTS);

	// sequencer state
	fmipr_pkg::state_t state_q, state_d;

	// table bookkeeping
	logic [CNT_W-1:0]            count_q;
	logic [fmipr_pkg::ID_W-1:0]  next_id_q;

	// request held while scanning
	fmipr_pkg::mode_t              mode_q;
	logic [fmipr_pkg::ID_W-1:0]    rule_id_q;
	logic [fmipr_pkg::ADDR_W-1:0]  addr_q;
	logic [fmipr_pkg::ADDR_W-1:0]  lo_q;
	logic [fmipr_pkg::ADDR_W-1:0]  hi_q;
	logic [1:0]                    act_q;
	logic                          en_q;

	// read pipeline: address issued, entry checked in the following cycle
	logic [CNT_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] chk_idx_q;
	logic             chk_valid_q;
	logic             chk_last_q;

	// result registers
	logic                       done_q;
	logic                       ok_q;
	logic [1:0]                 fact_q;
	logic [fmipr_pkg::ID_W-1:0] nid_q;

	fmipr_pkg::mode_t mode_in;
	logic             accept;

	// range built from the request fields
	logic [5:0]                   plen_c;
	logic [fmipr_pkg::ADDR_W-1:0] host_mask;
	logic [fmipr_pkg::ADDR_W-1:0] lo_c;
	logic [fmipr_pkg::ADDR_W-1:0] hi_c;

	// ram side
	logic              issue;
	logic [CNT_W-1:0]  rd_ptr;
	logic [CNT_W-1:0]  rd_next;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	fmipr_pkg::entry_t wdata;
	fmipr_pkg::entry_t rdata;
	logic [$bits(fmipr_pkg::entry_t)-1:0] rdata_raw;

	// finishing step of the current request
	logic                       fin;
	logic                       fin_ok;
	logic [1:0]                 fin_act;
	logic [fmipr_pkg::ID_W-1:0] fin_nid;
	logic                       lookup_hit;
	logic                       id_hit;

	assign mode_in = fmipr_pkg::mode_t'(mode);
	assign busy    = (state_q != fmipr_pkg::ST_IDLE);
	assign accept  = start && !busy;

	// prefix longer than the address is a single address, zero length covers everything
	always_comb begin
		plen_c    = (prefix_len > fmipr_pkg::ADDR_BITS) ? fmipr_pkg::ADDR_BITS : prefix_len;
		host_mask = fmipr_pkg::ALL_ONES >> plen_c;
		if (plen_c == 6'd0) begin
			host_mask = fmipr_pkg::ALL_ONES;
		end
		if (range_form == fmipr_pkg::FORM_PREFIX) begin
			lo_c = address & ~host_mask;
			hi_c = (address & ~host_mask) | host_mask;
		end else if (range_form == fmipr_pkg::FORM_RANGE) begin
			lo_c = address;
			hi_c = last_address;
		end else begin
			// single address, also for the unused form code
			lo_c = address;
			hi_c = address;
		end
	end

	assign rdata = fmipr_pkg::entry_t'(rdata_raw);

	// reversed ranges never satisfy both compares, so they match nothing
	assign lookup_hit = rdata.enabled && (addr_q >= rdata.first) && (addr_q <= rdata.last);
	assign id_hit     = (rdata.id == rule_id_q);

	// first read goes out in the request cycle so slot 0 is checked in the cycle after
	assign rd_ptr  = (state_q == fmipr_pkg::ST_IDLE) ? '0 : rd_idx_q;
	assign rd_next = rd_ptr + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmipr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		we      = 1'b0;
		waddr   = chk_idx_q;
		wdata   = rdata;
		fin     = 1'b0;
		fin_ok  = 1'b0;
		fin_act = fmipr_pkg::ACT_ALLOW;
		fin_nid = '0;
		unique case (state_q)
			fmipr_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (mode_in) inside
						fmipr_pkg::MODE_LOOKUP, fmipr_pkg::MODE_REMOVE,
						fmipr_pkg::MODE_UPDATE, fmipr_pkg::MODE_ENABLE,
						fmipr_pkg::MODE_DISABLE: begin
							if (count_q != '0) begin
								issue   = 1'b1;
								state_d = fmipr_pkg::ST_SCAN;
							end else begin
								// empty table: lookup allows, id search misses
								fin    = 1'b1;
								fin_ok = (mode_in == fmipr_pkg::MODE_LOOKUP);
							end
						end
						fmipr_pkg::MODE_ADD: begin
							fin = 1'b1;
							if (count_q < SLOTS_C) begin
								we            = 1'b1;
								waddr         = count_q[IDX_W-1:0];
								wdata.first   = lo_c;
								wdata.last    = hi_c;
								wdata.action  = rule_action;
								wdata.enabled = rule_enabled;
								wdata.id      = next_id_q;
								fin_ok        = 1'b1;
								fin_nid       = next_id_q;
							end
						end
						fmipr_pkg::MODE_CLEAR: begin
							fin    = 1'b1;
							fin_ok = 1'b1;
						end
						default: begin
							// unused mode code: no change, ok low
							fin = 1'b1;
						end
					endcase
				end
			end
			fmipr_pkg::ST_SCAN: begin
				issue = (rd_idx_q < count_q);
				if (chk_valid_q) begin
					if (mode_q == fmipr_pkg::MODE_LOOKUP) begin
						if (lookup_hit) begin
							fin     = 1'b1;
							fin_ok  = 1'b1;
							fin_act = rdata.action;
						end else if (chk_last_q) begin
							fin    = 1'b1;
							fin_ok = 1'b1;
						end
					end else if (id_hit) begin
						case (mode_q)
							fmipr_pkg::MODE_UPDATE: begin
								we            = 1'b1;
								wdata.first   = lo_q;
								wdata.last    = hi_q;
								wdata.action  = act_q;
								wdata.enabled = en_q;
								fin           = 1'b1;
								fin_ok        = 1'b1;
							end
							fmipr_pkg::MODE_ENABLE: begin
								we            = 1'b1;
								wdata.enabled = 1'b1;
								fin           = 1'b1;
								fin_ok        = 1'b1;
							end
							fmipr_pkg::MODE_DISABLE: begin
								we            = 1'b1;
								wdata.enabled = 1'b0;
								fin           = 1'b1;
								fin_ok        = 1'b1;
							end
							default: begin
								// remove: the read of the next slot is already in flight
								if (chk_last_q) begin
									fin    = 1'b1;
									fin_ok = 1'b1;
								end else begin
									state_d = fmipr_pkg::ST_SHIFT;
								end
							end
						endcase
					end else if (chk_last_q) begin
						fin = 1'b1;
					end
				end
			end
			fmipr_pkg::ST_SHIFT: begin
				// each later rule moves up one slot
				issue = (rd_idx_q < count_q);
				if (chk_valid_q) begin
					we    = 1'b1;
					waddr = chk_idx_q - IDX_W'(1);
					if (chk_last_q) begin
						fin    = 1'b1;
						fin_ok = 1'b1;
					end
				end
			end
			default: begin
				state_d = fmipr_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			issue   = 1'b0;
			state_d = fmipr_pkg::ST_IDLE;
		end
	end

	fmipr_ram #(
		.WIDTH ($bits(fmipr_pkg::entry_t)),
		.DEPTH (RULE_SLOTS),
		.ADDR_W(IDX_W)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (issue),
		.raddr(rd_ptr[IDX_W-1:0]),
		.rdata(rdata_raw)
	);

	// read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			chk_valid_q <= 1'b0;
			chk_last_q  <= 1'b0;
		end else begin
			chk_valid_q <= issue;
			if (issue) begin
				rd_idx_q   <= rd_next;
				chk_last_q <= (rd_next == count_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			chk_idx_q <= rd_ptr[IDX_W-1:0];
		end
	end

	// table count and id allocation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_id_q <= fmipr_pkg::ID_W'(1);
		end else if (state_q == fmipr_pkg::ST_IDLE) begin
			if (accept && (mode_in == fmipr_pkg::MODE_ADD) && fin_ok) begin
				count_q   <= count_q + CNT_W'(1);
				next_id_q <= next_id_q + fmipr_pkg::ID_W'(1);
			end else if (accept && (mode_in == fmipr_pkg::MODE_CLEAR)) begin
				count_q <= '0;
			end
		end else if (fin && fin_ok && (mode_q == fmipr_pkg::MODE_REMOVE)) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// request fields held for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode_in;
			rule_id_q <= rule_id;
			addr_q    <= address;
			lo_q      <= lo_c;
			hi_q      <= hi_c;
			act_q     <= rule_action;
			en_q      <= rule_enabled;
		end
	end

	// result strobe and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			ok_q   <= fin_ok;
			fact_q <= fin_act;
			nid_q  <= fin_nid;
		end
	end

	assign done         = done_q;
	assign ok           = ok_q;
	assign found_action = fact_q;
	assign allowed      = (fact_q != fmipr_pkg::ACT_BLOCK);
	assign new_id       = nid_q;

endmodule

@@ sv/fmipr_ram.sv @@
// generic simple dual-port ram with registered read
module fmipr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ tb/first_match_ip_range_filter_unit_tb.sv @@
// self-checking testbench of the first-match ip range filter with a rule table predictor
module first_match_ip_range_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fmipr_pkg::*;

	localparam int RULE_SLOTS  = 64;
	localparam int PHASE_ITEMS = 300;
	// longest tail after the last result: a full scan plus a full shift
	localparam int END_DRAIN   = 2 * RULE_SLOTS + 8;

	// codes the package does not name
	localparam logic [2:0] MODE_SPARE  = 3'd7;
	localparam logic [1:0] FORM_SINGLE = 2'd2;
	localparam logic [1:0] FORM_SPARE  = 2'd3;
	localparam logic [1:0] ACT_MARK2   = 2'd2;
	localparam logic [1:0] ACT_MARK3   = 2'd3;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] rule_id;
		logic [31:0] address;
		logic [31:0] last_address;
		logic [1:0]  range_form;
		logic [5:0]  prefix_len;
		logic [1:0]  rule_action;
		logic        rule_enabled;
	} filter_req_t;

	typedef struct packed {
		logic        ok;
		logic [1:0]  found_action;
		logic        allowed;
		logic [31:0] new_id;
	} filter_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	filter_req_t cur_req = '0;
	logic        busy;
	logic        done;
	logic        ok;
	logic [1:0]  found_action;
	logic        allowed;
	logic [31:0] new_id;

	// requests waiting to be driven, results waiting to be seen
	filter_req_t    pending_q[$];
	filter_result_t expected_q[$];
	filter_result_t want;

	// predicted rule table
	entry_t      rule_tbl [RULE_SLOTS];
	int          rule_count = 0;
	logic [31:0] id_next = 32'd1;

	// stimulus and bookkeeping
	int unsigned idle_pct = 29;
	int unsigned gen_adds = 0;
	bit          issue_next;
	int          mismatches = 0;
	int          requests_taken = 0;
	int          mode_seen [8];
	int          lookup_hits = 0;
	int          adds_refused = 0;
	int          id_misses = 0;
	int          phase;

	first_match_ip_range_filter_unit #(
		.RULE_SLOTS(RULE_SLOTS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (cur_req.mode),
		.rule_id     (cur_req.rule_id),
		.address     (cur_req.address),
		.last_address(cur_req.last_address),
		.range_form  (cur_req.range_form),
		.prefix_len  (cur_req.prefix_len),
		.rule_action (cur_req.rule_action),
		.rule_enabled(cur_req.rule_enabled),
		.done        (done),
		.ok          (ok),
		.found_action(found_action),
		.allowed     (allowed),
		.new_id      (new_id)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------- predictor

	// bounds of a rule as the table stores them
	function automatic entry_t make_entry(input filter_req_t r, input logic [31:0] rid);
		entry_t      e;
		logic [31:0] mask;
		logic [5:0]  plen;
		// an overlong prefix is clipped to a single address, a zero prefix is everything
		plen = (r.prefix_len > ADDR_BITS) ? ADDR_BITS : r.prefix_len;
		mask = (plen == 6'd0) ? '0 : ALL_ONES << (ADDR_BITS - plen);
		e.action  = r.rule_action;
		e.enabled = r.rule_enabled;
		e.id      = rid;
		case (r.range_form)
		FORM_PREFIX: begin
			e.first = r.address & mask;
			e.last  = e.first | ~mask;
		end
		FORM_RANGE: begin
			// a reversed range is kept as given and never matches
			e.first = r.address;
			e.last  = r.last_address;
		end
		default: begin
			// single address, the spare form included
			e.first = r.address;
			e.last  = r.address;
		end
		endcase
		return e;
	endfunction

	// first slot in table order that holds the id, -1 when none does
	function automatic int find_rule(input logic [31:0] rid);
		int k;
		k = 0;
		while (k < rule_count && rule_tbl[k].id != rid)
			k++;
		return (k < rule_count) ? k : -1;
	endfunction

	// applies one request to the predicted table and returns its result
	function automatic filter_result_t apply_request(input filter_req_t r);
		filter_result_t res;
		int             hit;
		int             j;
		res = '{ok: 1'b0, found_action: ACT_ALLOW, allowed: 1'b1, new_id: '0};
		mode_seen[r.mode]++;
		case (r.mode)
		MODE_LOOKUP: begin
			res.ok = 1'b1;
			hit = 0;
			while (hit < rule_count && !(rule_tbl[hit].enabled &&
					r.address >= rule_tbl[hit].first && r.address <= rule_tbl[hit].last))
				hit++;
			if (hit < rule_count) begin
				res.found_action = rule_tbl[hit].action;
				lookup_hits++;
			end
			res.allowed = (res.found_action != ACT_BLOCK);
		end
		MODE_ADD: begin
			// a full table refuses the rule and keeps the id counter
			if (rule_count < RULE_SLOTS) begin
				rule_tbl[rule_count] = make_entry(r, id_next);
				res.new_id = id_next;
				res.ok     = 1'b1;
				id_next++;
				rule_count++;
			end else begin
				adds_refused++;
			end
		end
		MODE_REMOVE, MODE_UPDATE, MODE_ENABLE, MODE_DISABLE: begin
			hit = find_rule(r.rule_id);
			if (hit < 0) begin
				id_misses++;
			end else begin
				res.ok = 1'b1;
				case (r.mode)
				MODE_REMOVE: begin
					// later rules close the gap in order
					for (j = hit; j + 1 < rule_count; j++)
						rule_tbl[j] = rule_tbl[j + 1];
					rule_count--;
				end
				MODE_UPDATE: rule_tbl[hit] = make_entry(r, rule_tbl[hit].id);
				MODE_ENABLE: rule_tbl[hit].enabled = 1'b1;
				default:     rule_tbl[hit].enabled = 1'b0;
				endcase
			end
		end
		MODE_CLEAR: begin
			// ids keep counting across a clear
			rule_count = 0;
			res.ok     = 1'b1;
		end
		default: ;
		endcase
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic filter_req_t req_of(input logic [2:0] m, input logic [31:0] rid,
			input logic [31:0] addr, input logic [31:0] last, input logic [1:0] form,
			input logic [5:0] plen, input logic [1:0] act, input logic en);
		filter_req_t r;
		r = '{mode: m, rule_id: rid, address: addr, last_address: last, range_form: form,
			prefix_len: plen, rule_action: act, rule_enabled: en};
		return r;
	endfunction

	// keeps a rough count of issued ids so id searches mostly hit live rules
	task automatic queue_request(input filter_req_t r);
		if (r.mode == MODE_ADD)
			gen_adds++;
		pending_q = {pending_q, r};
	endtask

	// addresses cluster in a small block so rules overlap and lookups hit them
	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 9))
		0:       return $urandom_range(0, 1) ? ALL_ONES : '0;
		1, 2:    return $urandom;
		default: return {8'd10, 6'd0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				8'($urandom)};
		endcase
	endfunction

	function automatic logic [31:0] pick_rule_id();
		int unsigned lo_id;
		case ($urandom_range(0, 9))
		0: return $urandom;
		1: return $urandom_range(0, 1) ? ALL_ONES : '0;
		default: begin
			// recent ids, a couple not issued yet
			lo_id = (gen_adds > 70) ? gen_adds - 70 : 1;
			return $urandom_range(lo_id, gen_adds + 2);
		end
		endcase
	endfunction

	function automatic logic [2:0] pick_mode();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 40) return MODE_LOOKUP;
		if (p < 64) return MODE_ADD;
		if (p < 73) return MODE_REMOVE;
		if (p < 81) return MODE_UPDATE;
		if (p < 89) return MODE_ENABLE;
		if (p < 97) return MODE_DISABLE;
		if (p < 99) return MODE_CLEAR;
		return MODE_SPARE;
	endfunction

	function automatic filter_req_t random_request(input logic [2:0] m);
		filter_req_t r;
		int unsigned p;
		r.mode    = m;
		r.rule_id = pick_rule_id();
		r.address = pick_address();
		p = $urandom_range(0, 19);
		r.range_form   = (p < 9) ? FORM_PREFIX : (p < 16) ? FORM_RANGE :
				(p < 19) ? FORM_SINGLE : FORM_SPARE;
		r.prefix_len   = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(8, 32)) :
				6'($urandom_range(0, 63));
		// mostly a short forward range, sometimes anything (often reversed)
		r.last_address = ($urandom_range(0, 6) != 0) ?
				r.address + 32'($urandom_range(0, 'h3_FFFF)) : 32'($urandom);
		r.rule_action  = 2'($urandom);
		r.rule_enabled = ($urandom_range(0, 6) != 0);
		return r;
	endfunction

	// one phase of random traffic with one table-filling sequence somewhere in it
	task automatic queue_phase();
		int n;
		int burst_at;
		int k;
		n = 0;
		burst_at = $urandom_range(0, PHASE_ITEMS - 100);
		while (n < PHASE_ITEMS) begin
			if (n == burst_at) begin
				// fill past capacity, probe, punch holes, refill, probe again
				queue_request(random_request(MODE_CLEAR));
				for (k = 0; k < RULE_SLOTS + 2; k++)
					queue_request(random_request(MODE_ADD));
				for (k = 0; k < 12; k++)
					queue_request(random_request(MODE_LOOKUP));
				for (k = 0; k < 3; k++)
					queue_request(random_request(MODE_REMOVE));
				for (k = 0; k < 2; k++)
					queue_request(random_request(MODE_ADD));
				for (k = 0; k < 8; k++)
					queue_request(random_request(MODE_LOOKUP));
				n += RULE_SLOTS + 28;
			end else begin
				queue_request(random_request(pick_mode()));
				n++;
			end
		end
	endtask

	// ---------------------------------------------------------------- driver

	// start stays up until the request is taken; a new request may follow at once
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			issue_next = !start;
			if (start && !busy) begin
				expected_q = {expected_q, apply_request(cur_req)};
				requests_taken++;
				issue_next = 1'b1;
			end
			if (issue_next) begin
				if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur_req <= pending_q.pop_front();
					start   <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	// done marks a one-cycle result; it is compared against the oldest request
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, ok %b action %0d allowed %b id %0h",
					$time, ok, found_action, allowed, new_id);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_field("ok", 32'(want.ok), 32'(ok));
				check_field("found_action", 32'(want.found_action), 32'(found_action));
				check_field("allowed", 32'(want.allowed), 32'(allowed));
				check_field("new_id", want.new_id, new_id);
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: nothing matches, every id search misses, the spare mode is refused
		queue_request(req_of(MODE_LOOKUP, '0, '0, '0, FORM_PREFIX, 6'd0, ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES, FORM_SPARE, 6'd63,
			ACT_MARK3, 1'b1));
		queue_request(req_of(MODE_REMOVE, 32'd1, '0, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_UPDATE, ALL_ONES, '0, '0, FORM_RANGE, 6'd8,
			ACT_BLOCK, 1'b1));
		queue_request(req_of(MODE_ENABLE, 32'd1, '0, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_DISABLE, '0, '0, '0, FORM_PREFIX, 6'd0, ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_SPARE, 32'd1, 32'h0A00_0001, '0, FORM_PREFIX, 6'd8,
			ACT_BLOCK, 1'b1));
		// zero-length prefix covers everything, blocking (id 1)
		queue_request(req_of(MODE_ADD, '0, ALL_ONES, '0, FORM_PREFIX, 6'd0,
			ACT_BLOCK, 1'b1));
		queue_request(req_of(MODE_LOOKUP, '0, 32'h1234_5678, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		// 10/8 allow sits behind rule 1 until rule 1 is disabled (id 2)
		queue_request(req_of(MODE_ADD, '0, 32'h0A12_3456, '0, FORM_PREFIX, 6'd8,
			ACT_ALLOW, 1'b1));
		queue_request(req_of(MODE_DISABLE, 32'd1, '0, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_LOOKUP, '0, 32'h0A01_0203, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		// overlong prefix is a single address (id 3)
		queue_request(req_of(MODE_ADD, '0, 32'hC0A8_0001, '0, FORM_PREFIX, 6'd33,
			ACT_MARK3, 1'b1));
		queue_request(req_of(MODE_LOOKUP, '0, 32'hC0A8_0001, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_LOOKUP, '0, 32'hC0A8_0002, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		// reversed explicit range never matches (id 4)
		queue_request(req_of(MODE_ADD, '0, 32'h2000_0000, 32'h1000_0000, FORM_RANGE, 6'd0,
			ACT_BLOCK, 1'b1));
		queue_request(req_of(MODE_LOOKUP, '0, 32'h1800_0000, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		// spare range form acts as a single address (id 5)
		queue_request(req_of(MODE_ADD, '0, 32'h7F00_0001, ALL_ONES, FORM_SPARE, 6'd63,
			ACT_BLOCK, 1'b1));
		queue_request(req_of(MODE_LOOKUP, '0, 32'h7F00_0001, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		// update keeps id 3 and widens it to everything with a pass-through action
		queue_request(req_of(MODE_UPDATE, 32'd3, '0, ALL_ONES, FORM_RANGE, 6'd0,
			ACT_MARK2, 1'b1));
		queue_request(req_of(MODE_LOOKUP, '0, 32'h0000_0005, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		// remove from the middle, then rule 1 back on in front
		queue_request(req_of(MODE_REMOVE, 32'd2, '0, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_ENABLE, 32'd1, '0, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_LOOKUP, '0, 32'h0A00_0001, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));
		// clear keeps the id counter; a disabled rule never decides
		queue_request(req_of(MODE_CLEAR, '0, '0, '0, FORM_PREFIX, 6'd0, ACT_ALLOW, 1'b0));
		queue_request(req_of(MODE_ADD, '0, ALL_ONES, '0, FORM_SINGLE, 6'd0,
			ACT_MARK2, 1'b0));
		queue_request(req_of(MODE_LOOKUP, '0, ALL_ONES, '0, FORM_PREFIX, 6'd0,
			ACT_ALLOW, 1'b0));

		// sender idles often, then very often, then never
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 29 : (phase == 1) ? 63 : 0;
			queue_phase();
			do
				@(negedge clk);
			while (pending_q.size() != 0 || start || busy || expected_q.size() != 0);
		end

		// catch any stray result after the last one
		repeat (END_DRAIN) @(negedge clk);

		$display("covered %0d requests, %0d lookups (%0d hit), %0d adds (%0d refused)",
			requests_taken, mode_seen[MODE_LOOKUP], lookup_hits, mode_seen[MODE_ADD],
			adds_refused);
		$display("  %0d removes %0d updates %0d enables %0d disables %0d clears %0d spare",
			mode_seen[MODE_REMOVE], mode_seen[MODE_UPDATE], mode_seen[MODE_ENABLE],
			mode_seen[MODE_DISABLE], mode_seen[MODE_CLEAR], mode_seen[MODE_SPARE]);
		$display("  %0d id misses, %0d mismatches", id_misses, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#12_000_000;
		$display("timeout with %0d requests queued and %0d results outstanding",
			pending_q.size(), expected_q.size());
		$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/fmipr_pkg.sv
sv/fmipr_ram.sv
sv/first_match_ip_range_filter_unit.sv
tb/first_match_ip_range_filter_unit_tb.sv
